// File: design/sequential_list_engine_defines.svh
// Assertion macros used by the list engine source.
`ifndef SEQUENTIAL_LIST_ENGINE_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SLE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list engine assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list engine assertion failed");

`endif

// File: design/sle_pkg.sv
package sle_pkg;

    localparam int CAPACITY = 128;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int REQ_W    = 4;
    localparam int POS_W    = 8;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 3;
    localparam int FOUND_W  = 7;
    localparam int ICNT_W   = 8;

    localparam logic [REQ_W-1:0] REQ_INSERT     = 4'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 4'd1;
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 4'd2;
    localparam logic [REQ_W-1:0] REQ_ERASE      = 4'd3;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 4'd4;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 4'd5;
    localparam logic [REQ_W-1:0] REQ_REMOVE     = 4'd6;
    localparam logic [REQ_W-1:0] REQ_FIND       = 4'd7;
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 4'd8;

    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd4;

    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic signed [VAL_W-1:0] val_t;

    localparam cnt_t CNT_CAP = CNT_W'(CAPACITY);

    typedef struct packed {
        logic en;
        idx_t addr;
        val_t data;
    } sle_wr_t;

    typedef struct packed {
        logic en;
        idx_t addr;
    } sle_rd_t;

endpackage

// File: design/sle_ifs.sv
interface sle_req_if;
    import sle_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic [POS_W-1:0]         position;
    logic signed [VAL_W-1:0]  value;

    modport source (output valid, output req_type, output position, output value,
                    input ready);
    modport sink   (input valid, input req_type, input position, input value,
                    output ready);
endinterface

interface sle_rsp_if;
    import sle_pkg::*;

    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic [FOUND_W-1:0]  found_index;
    logic [ICNT_W-1:0]   item_count;

    modport source (output valid, output status, output found_index, output item_count,
                    input ready);
    modport sink   (input valid, input status, input found_index, input item_count,
                    output ready);
endinterface

// File: design/sequential_list_engine.sv
// Clear, pop back, an unused code and any rejected request go straight to the response.
// An insert or a push shifts the entries from its position to the tail up, then writes the
// value; an erase or a pop front shifts the entries above its position down; a find searches
// from index 0 until it hits, and a remove searches, then shifts the rest down. The memory walk
// moves one entry per cycle; one request is in flight at a time, and a response beat that waits
// on rsp.ready holds the next response back. Reset clears the count and control state.
module sequential_list_engine (
    input  logic       clk,
    input  logic       rst_n,
    sle_req_if.sink    req,
    sle_rsp_if.source  rsp
);
    import sle_pkg::*;
    `include "sequential_list_engine_defines.svh"

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_UP,
        ST_INS_WR,
        ST_SHIFT_DN,
        ST_SEARCH,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    idx_t                cursor_reg, cursor_next;
    idx_t                at_reg, at_next;
    cnt_t                count_reg, count_next;
    val_t                value_reg, value_next;
    logic                is_find_reg, is_find_next;
    logic [STAT_W-1:0]   res_status_reg, res_status_next;
    idx_t                res_found_reg, res_found_next;
    logic                out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]   out_status_reg, out_status_next;
    logic [FOUND_W-1:0]  out_found_reg, out_found_next;
    logic [ICNT_W-1:0]   out_count_reg, out_count_next;

    sle_wr_t             wr;
    sle_rd_t             rd;
    val_t                rd_data;
    logic                req_acc;
    idx_t                last_idx;
    cnt_t                cursor_ext;
    logic [POS_W-1:0]    ins_at;
    logic [POS_W-1:0]    del_at;

    sle_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    assign req.ready   = (state_reg == ST_IDLE);
    assign req_acc     = req.valid && req.ready;
    assign last_idx    = IDX_W'(count_reg - CNT_W'(1));
    assign cursor_ext  = CNT_W'(cursor_reg);

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.found_index = out_found_reg;
    assign rsp.item_count  = out_count_reg;

    always_comb
    begin
        if (req.req_type == REQ_INSERT)
        begin
            ins_at = req.position;
        end
        else if (req.req_type == REQ_PUSH_BACK)
        begin
            ins_at = POS_W'(count_reg);
        end
        else
        begin
            ins_at = '0;
        end
        del_at = (req.req_type == REQ_ERASE) ? req.position : '0;
    end

    always_comb
    begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        at_next         = at_reg;
        count_next      = count_reg;
        value_next      = value_reg;
        is_find_next    = is_find_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_count_next  = out_count_reg;
        wr              = '0;
        rd              = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    value_next      = req.value;
                    is_find_next    = (req.req_type == REQ_FIND);
                    res_status_next = STAT_OK;
                    res_found_next  = '0;
                    state_next      = ST_DONE;
                    unique case (req.req_type) inside
                        REQ_INSERT, REQ_PUSH_BACK, REQ_PUSH_FRONT:
                        begin
                            if (count_reg == CNT_CAP)
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else if (32'(ins_at) > 32'(count_reg))
                            begin
                                res_status_next = STAT_RANGE;
                            end
                            else
                            begin
                                at_next = IDX_W'(ins_at);
                                if (32'(ins_at) == 32'(count_reg))
                                begin
                                    state_next = ST_INS_WR;
                                end
                                else
                                begin
                                    rd.en       = 1'b1;
                                    rd.addr     = last_idx;
                                    cursor_next = last_idx;
                                    state_next  = ST_SHIFT_UP;
                                end
                            end
                        end
                        REQ_ERASE, REQ_POP_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STAT_EMPTY;
                            end
                            else if (32'(del_at) >= 32'(count_reg))
                            begin
                                res_status_next = STAT_RANGE;
                            end
                            else if (IDX_W'(del_at) == last_idx)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                rd.en       = 1'b1;
                                rd.addr     = IDX_W'(del_at) + IDX_W'(1);
                                cursor_next = IDX_W'(del_at) + IDX_W'(1);
                                state_next  = ST_SHIFT_DN;
                            end
                        end
                        REQ_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        REQ_REMOVE, REQ_FIND:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                rd.en       = 1'b1;
                                rd.addr     = '0;
                                cursor_next = '0;
                                state_next  = ST_SEARCH;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SHIFT_UP:
            begin
                wr.en   = 1'b1;
                wr.addr = cursor_reg + IDX_W'(1);
                wr.data = rd_data;
                if (cursor_reg == at_reg)
                begin
                    state_next = ST_INS_WR;
                end
                else
                begin
                    rd.en       = 1'b1;
                    rd.addr     = cursor_reg - IDX_W'(1);
                    cursor_next = cursor_reg - IDX_W'(1);
                end
            end

            ST_INS_WR:
            begin
                wr.en      = 1'b1;
                wr.addr    = at_reg;
                wr.data    = value_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_DONE;
            end

            ST_SHIFT_DN:
            begin
                wr.en   = 1'b1;
                wr.addr = cursor_reg - IDX_W'(1);
                wr.data = rd_data;
                if (cursor_reg == last_idx)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_DONE;
                end
                else
                begin
                    rd.en       = 1'b1;
                    rd.addr     = cursor_reg + IDX_W'(1);
                    cursor_next = cursor_reg + IDX_W'(1);
                end
            end

            ST_SEARCH:
            begin
                if (rd_data == value_reg)
                begin
                    if (is_find_reg)
                    begin
                        res_found_next = cursor_reg;
                        state_next     = ST_DONE;
                    end
                    else if (cursor_reg == last_idx)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        rd.en       = 1'b1;
                        rd.addr     = cursor_reg + IDX_W'(1);
                        cursor_next = cursor_reg + IDX_W'(1);
                        state_next  = ST_SHIFT_DN;
                    end
                end
                else if (cursor_reg == last_idx)
                begin
                    res_status_next = STAT_NOTFOUND;
                    state_next      = ST_DONE;
                end
                else
                begin
                    rd.en       = 1'b1;
                    rd.addr     = cursor_reg + IDX_W'(1);
                    cursor_next = cursor_reg + IDX_W'(1);
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_found_next  = FOUND_W'(res_found_reg);
                    out_count_next  = ICNT_W'(count_reg);
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            cursor_reg     <= '0;
            at_reg         <= '0;
            value_reg      <= '0;
            is_find_reg    <= 1'b0;
            res_status_reg <= STAT_OK;
            res_found_reg  <= '0;
            out_status_reg <= STAT_OK;
            out_found_reg  <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            cursor_reg     <= cursor_next;
            at_reg         <= at_next;
            value_reg      <= value_next;
            is_find_reg    <= is_find_next;
            res_status_reg <= res_status_next;
            res_found_reg  <= res_found_next;
            out_status_reg <= out_status_next;
            out_found_reg  <= out_found_next;
            out_count_reg  <= out_count_next;
        end
    end

    `SLE_ASSERT_NOW(a_count_cap, 1'b1, count_reg <= CNT_CAP)
    `SLE_ASSERT_NEXT(a_idle_count_hold, state_reg == ST_IDLE && !req_acc, count_reg == $past(count_reg))
    `SLE_ASSERT_NOW(a_walk_in_list, state_reg == ST_SEARCH || state_reg == ST_SHIFT_DN, cursor_ext < count_reg)
    `SLE_ASSERT_NOW(a_write_states, wr.en, state_reg == ST_SHIFT_UP || state_reg == ST_SHIFT_DN || state_reg == ST_INS_WR)

endmodule

// File: design/sle_store.sv
module sle_store (
    input  logic             clk,
    input  sle_pkg::sle_wr_t wr,
    input  sle_pkg::sle_rd_t rd,
    output sle_pkg::val_t    rd_data
);
    import sle_pkg::*;

    val_t mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

// File: tb/sequential_list_engine_test.sv
`timescale 1ns / 100ps

module sequential_list_engine_test;
    import sle_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int CYCLE_LIMIT = 800000;
    localparam int TAIL_CYCLES = 150;

    localparam logic [REQ_W-1:0] REQ_UNUSED_LO = REQ_CLEAR + REQ_W'(1);
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI = {REQ_W{1'b1}};

    localparam int MODE_GROW = 0;
    localparam int MODE_MIXED = 1;
    localparam int MODE_SHRINK = 2;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [POS_W-1:0] position;
        val_t             value;
    } list_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [FOUND_W-1:0] found_index;
        logic [ICNT_W-1:0]  item_count;
    } list_reply_t;

    logic clk;
    logic rst_n;

    sle_req_if req_bus ();
    sle_rsp_if rsp_bus ();

    sequential_list_engine u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    list_req_t   pending_reqs[$];
    list_reply_t replies_due[$];
    val_t        list_contents[$];
    val_t        value_pool[8];

    list_req_t next_req;
    logic      req_taken;
    int        total_items;
    int        sent_count;
    int        gap_pct;
    int        stall_pct;
    int        gen_count;
    int        error_count;
    int        cycle_count;

    always #HALF_PERIOD clk = ~clk;

    task automatic apply_request(input logic [REQ_W-1:0] rt, input logic [POS_W-1:0] pos,
                                 input val_t v);
        list_reply_t r;
        int          hit;
        int          k;
        r = '0;
        hit = -1;
        if (rt == REQ_REMOVE || rt == REQ_FIND) begin
            for (k = 0; k < list_contents.size(); k++) begin
                if (hit < 0 && list_contents[k] == v) begin
                    hit = k;
                end
            end
        end
        case (rt)
            REQ_INSERT:
                if (list_contents.size() >= CAPACITY) r.status = STAT_FULL;
                else if (pos > list_contents.size()) r.status = STAT_RANGE;
                else list_contents.insert(pos, v);
            REQ_PUSH_BACK:
                if (list_contents.size() >= CAPACITY) r.status = STAT_FULL;
                else list_contents.push_back(v);
            REQ_PUSH_FRONT:
                if (list_contents.size() >= CAPACITY) r.status = STAT_FULL;
                else list_contents.push_front(v);
            REQ_ERASE:
                if (list_contents.size() == 0) r.status = STAT_EMPTY;
                else if (pos >= list_contents.size()) r.status = STAT_RANGE;
                else list_contents.delete(pos);
            REQ_POP_BACK:
                if (list_contents.size() == 0) r.status = STAT_EMPTY;
                else void'(list_contents.pop_back());
            REQ_POP_FRONT:
                if (list_contents.size() == 0) r.status = STAT_EMPTY;
                else void'(list_contents.pop_front());
            REQ_REMOVE:
                if (list_contents.size() == 0) r.status = STAT_EMPTY;
                else if (hit < 0) r.status = STAT_NOTFOUND;
                else list_contents.delete(hit);
            REQ_FIND:
                if (list_contents.size() == 0) r.status = STAT_EMPTY;
                else if (hit < 0) r.status = STAT_NOTFOUND;
                else r.found_index = FOUND_W'(hit);
            REQ_CLEAR:
                list_contents.delete();
            default: ;
        endcase
        r.item_count = ICNT_W'(list_contents.size());
        replies_due.push_back(r);
    endtask

    function automatic val_t pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6) return value_pool[$urandom_range(0, 7)];
        if (roll == 6) return $urandom_range(0, 1) ? val_t'(32'h7fff_ffff) : val_t'(32'h8000_0000);
        return val_t'($urandom);
    endfunction

    function automatic list_req_t make_request(input int mode);
        list_req_t q;
        int        roll;
        int        op_lim[8];
        logic [REQ_W-1:0] op_code[8];
        int        k;
        op_code = '{REQ_INSERT, REQ_PUSH_BACK, REQ_PUSH_FRONT, REQ_ERASE,
                    REQ_POP_BACK, REQ_POP_FRONT, REQ_REMOVE, REQ_FIND};
        case (mode)
            MODE_GROW:   op_lim = '{30, 60, 88, 90, 92, 94, 96, 100};
            MODE_MIXED:  op_lim = '{12, 24, 36, 48, 58, 68, 80, 96};
            default:     op_lim = '{8, 14, 20, 40, 55, 70, 82, 96};
        endcase
        q.value = pick_value();
        q.position = POS_W'($urandom_range(0, 255));
        q.req_type = (mode != MODE_GROW && $urandom_range(0, 1)) ? REQ_CLEAR
                     : REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
        roll = $urandom_range(0, 99);
        for (k = 7; k >= 0; k--) begin
            if (roll < op_lim[k]) q.req_type = op_code[k];
        end
        roll = $urandom_range(0, 9);
        if (q.req_type == REQ_INSERT && roll < 8) begin
            q.position = POS_W'($urandom_range(0, gen_count));
        end else if (q.req_type == REQ_INSERT && roll == 8) begin
            q.position = POS_W'(gen_count);
        end else if (q.req_type == REQ_ERASE && roll < 9 && gen_count > 0) begin
            q.position = POS_W'($urandom_range(0, gen_count - 1));
        end
        case (q.req_type)
            REQ_INSERT:
                if (gen_count < CAPACITY && q.position <= gen_count) gen_count++;
            REQ_PUSH_BACK, REQ_PUSH_FRONT:
                if (gen_count < CAPACITY) gen_count++;
            REQ_ERASE:
                if (q.position < gen_count) gen_count--;
            REQ_POP_BACK, REQ_POP_FRONT, REQ_REMOVE:
                if (gen_count > 0) gen_count--;
            REQ_CLEAR:
                gen_count = 0;
            default: ;
        endcase
        return q;
    endfunction

    task automatic add_req(input logic [REQ_W-1:0] rt, input int pos, input val_t v);
        pending_reqs.push_back('{rt, POS_W'(pos), v});
    endtask

    // Driver: request beats and response back-pressure change on the falling edge.
    always @(negedge clk) begin
        case ((sent_count * 8 / total_items) % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 60; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 60; end
            default: begin gap_pct = 8; stall_pct = 8; end
        endcase
        if (!rst_n) begin
            req_bus.valid <= 1'b0;
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
            if (!req_bus.valid || req_taken) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
                    next_req = pending_reqs.pop_front();
                    req_bus.valid    <= 1'b1;
                    req_bus.req_type <= next_req.req_type;
                    req_bus.position <= next_req.position;
                    req_bus.value    <= next_req.value;
                    sent_count++;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks response beats, then predicts from the accepted request beat.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= req_bus.valid && req_bus.ready;
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (replies_due.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected response beat, expected none, actual %0d/%0d/%0d",
                             $time, rsp_bus.status, rsp_bus.found_index,
                             rsp_bus.item_count);
                end else begin
                    if (rsp_bus.status !== replies_due[0].status) begin
                        error_count++;
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, replies_due[0].status, rsp_bus.status);
                    end
                    if (rsp_bus.found_index !== replies_due[0].found_index) begin
                        error_count++;
                        $display("%0t: found_index mismatch, expected %0d, actual %0d",
                                 $time, replies_due[0].found_index, rsp_bus.found_index);
                    end
                    if (rsp_bus.item_count !== replies_due[0].item_count) begin
                        error_count++;
                        $display("%0t: item_count mismatch, expected %0d, actual %0d",
                                 $time, replies_due[0].item_count, rsp_bus.item_count);
                    end
                    void'(replies_due.pop_front());
                end
            end
            if (req_bus.valid && req_bus.ready) begin
                apply_request(req_bus.req_type, req_bus.position, req_bus.value);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int seg;
        int mode;
        int n;
        clk = 1'b0;
        rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.req_type = '0;
        req_bus.position = '0;
        req_bus.value = '0;
        rsp_bus.ready = 1'b0;
        req_taken = 1'b0;
        sent_count = 0;
        error_count = 0;
        cycle_count = 0;
        gen_count = 0;
        total_items = 1;
        value_pool = '{32'sd0, -32'sd1, 32'sh7fff_ffff, 32'sh8000_0000, val_t'($urandom),
                       val_t'($urandom), val_t'($urandom), val_t'($urandom)};

        // Empty list first, then a few known shapes and every rejection but a full list.
        add_req(REQ_CLEAR, 0, 0);
        add_req(REQ_POP_BACK, 0, 0);
        add_req(REQ_POP_FRONT, 0, 0);
        add_req(REQ_ERASE, 0, 0);
        add_req(REQ_FIND, 0, 0);
        add_req(REQ_REMOVE, 0, 0);
        add_req(REQ_INSERT, 1, 7);
        add_req(REQ_INSERT, 0, 32'sh7fff_ffff);
        add_req(REQ_PUSH_BACK, 0, 32'sh8000_0000);
        add_req(REQ_PUSH_FRONT, 0, -32'sd1);
        add_req(REQ_PUSH_BACK, 255, 0);
        add_req(REQ_INSERT, 4, 5);
        add_req(REQ_INSERT, 2, 32'sh1234_5678);
        add_req(REQ_INSERT, 5, 32'sh1234_5678);
        add_req(REQ_FIND, 0, -32'sd1);
        add_req(REQ_FIND, 0, 32'sh1234_5678);
        add_req(REQ_FIND, 0, 99);
        add_req(REQ_REMOVE, 0, 32'sh8000_0000);
        add_req(REQ_REMOVE, 0, 99);
        add_req(REQ_ERASE, 255, 0);
        add_req(REQ_ERASE, 1, 0);
        add_req(REQ_POP_FRONT, 0, 0);
        add_req(REQ_POP_BACK, 0, 0);
        add_req(REQ_UNUSED_HI, 255, -32'sd1);
        add_req(REQ_UNUSED_LO, 0, 0);
        add_req(REQ_CLEAR, 0, 0);

        // Grow until full, churn, drain, then repeat with the list refilled.
        for (seg = 0; seg < 5; seg++) begin
            mode = (seg % 3 == 0) ? MODE_GROW : (seg % 3 == 1) ? MODE_MIXED : MODE_SHRINK;
            n = (mode == MODE_GROW) ? 170 : (mode == MODE_MIXED) ? 115 : 150;
            repeat (n) pending_reqs.push_back(make_request(mode));
        end
        total_items = pending_reqs.size();

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        while (pending_reqs.size() != 0 || req_bus.valid) @(negedge clk);
        while (replies_due.size() != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (error_count == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule
